@@ src/qsort_pkg.sv @@
// ----------------------------------------------------------------------------
// qsort_pkg
// shared types, constants and controller encodings for the quicksort engine
// ----------------------------------------------------------------------------
package qsort_pkg;

    localparam int SIZE_DEF      = 64;
    localparam int DATA_BITS_DEF = 32;
    localparam int VALUE_W       = 32;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last_item;
    } in_word_t;

    typedef struct packed {
        logic [VALUE_W-1:0] sorted_value;
        logic               end_of_set;
        logic               dropped;
    } out_word_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_START,
        ST_POP,
        ST_POP_WT,
        ST_PIV_RD,
        ST_PIV_WT,
        ST_J_RD,
        ST_J_WT,
        ST_J_CHK,
        ST_I_RD,
        ST_I_WT,
        ST_I_CHK,
        ST_SW_WJ,
        ST_LOOP,
        ST_P_RD,
        ST_P_WT,
        ST_P_CHK,
        ST_PL_RD,
        ST_PL_WT,
        ST_PL_WR,
        ST_PUSH,
        ST_EMIT_RD,
        ST_EMIT_WT,
        ST_EMIT_OUT
    } state_t;

    // memory command from controller to datapath
    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_RD,
        MEM_WR_IN,
        MEM_WR_HOLD,
        MEM_WR_B
    } mem_op_t;

    typedef struct packed {
        mem_op_t     op;
        logic [5:0]  addr;
        logic        cap_a;   // capture read data into hold register a
        logic        cap_b;   // capture read data into hold register b
        logic        cap_piv; // capture read data as pivot
    } dp_cmd_t;

    typedef struct packed {
        logic lt_piv;   // last read element below pivot
    } dp_stat_t;

endpackage

@@ src/qsort_datapath.sv @@
// ----------------------------------------------------------------------------
// qsort_datapath
// element memory, hold registers and pivot compare
// ----------------------------------------------------------------------------
module qsort_datapath #(
    parameter int SIZE      = qsort_pkg::SIZE_DEF,
    parameter int DATA_BITS = qsort_pkg::DATA_BITS_DEF
) (
    input  logic                      clk,
    input  logic [qsort_pkg::VALUE_W-1:0] in_value,
    input  qsort_pkg::dp_cmd_t        cmd,
    output qsort_pkg::dp_stat_t       stat,
    output logic [qsort_pkg::VALUE_W-1:0] rd_value
);
    localparam int AW = (SIZE > 1) ? $clog2(SIZE) : 1;

    logic [DATA_BITS-1:0] mem [SIZE];
    logic [DATA_BITS-1:0] rd_reg;
    logic [DATA_BITS-1:0] hold_a_reg;
    logic [DATA_BITS-1:0] hold_b_reg;
    logic [DATA_BITS-1:0] piv_reg;
    logic [DATA_BITS-1:0] in_ext;
    logic [AW-1:0]        addr;

    assign addr = cmd.addr[AW-1:0];

    generate
        if (DATA_BITS > qsort_pkg::VALUE_W)
        begin : g_wide
            assign in_ext = {{(DATA_BITS-qsort_pkg::VALUE_W){1'b0}}, in_value};
            assign rd_value = rd_reg[qsort_pkg::VALUE_W-1:0];
        end
        else
        begin : g_narrow
            assign in_ext = in_value[DATA_BITS-1:0];
            assign rd_value = {{(qsort_pkg::VALUE_W-DATA_BITS){1'b0}}, rd_reg};
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            qsort_pkg::MEM_RD:      rd_reg <= mem[addr];
            qsort_pkg::MEM_WR_IN:   mem[addr] <= in_ext;
            qsort_pkg::MEM_WR_HOLD: mem[addr] <= hold_a_reg;
            qsort_pkg::MEM_WR_B:    mem[addr] <= hold_b_reg;
            default:                ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_a)
            hold_a_reg <= rd_reg;
        if (cmd.cap_b)
            hold_b_reg <= rd_reg;
        if (cmd.cap_piv)
            piv_reg <= rd_reg;
    end

    assign stat.lt_piv = $signed(rd_reg) < $signed(piv_reg);
endmodule

@@ src/qsort_ctrl.sv @@
// ----------------------------------------------------------------------------
// qsort_ctrl
// load, partition, range stack and emission sequencer
// ----------------------------------------------------------------------------
module qsort_ctrl #(
    parameter int SIZE = qsort_pkg::SIZE_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 out_end,
    output logic                 out_drop,
    output qsort_pkg::dp_cmd_t   cmd,
    input  qsort_pkg::dp_stat_t  stat
);
    localparam int CW = $clog2(SIZE + 1);

    qsort_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [6:0]    sp_reg, sp_next;
    logic          ovf_reg, ovf_next;
    logic [6:0]    lo_reg, lo_next, hi_reg, hi_next;
    logic [6:0]    i_reg, i_next, j_reg, j_next, p_reg, p_next;
    logic [6:0]    k_reg, k_next;
    logic          ov_reg, ov_next, oe_reg, oe_next;
    logic [1:0]    push_reg, push_next;
    logic [11:0]   stk [64];
    logic [11:0]   stk_rd_reg;
    logic [5:0]    stk_ra;
    logic          stk_we;
    logic [5:0]    stk_wa;
    logic [11:0]   stk_wd;

    assign out_valid = ov_reg;
    assign out_end = oe_reg;
    assign out_drop = ovf_reg;
    // top of stack, read into a register ahead of use
    assign stk_ra = 6'(sp_reg - 1'b1);

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk[stk_wa] <= stk_wd;
        stk_rd_reg <= stk[stk_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qsort_pkg::ST_LOAD;
            count_reg <= '0;
            sp_reg    <= '0;
            ovf_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            oe_reg    <= 1'b0;
            push_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sp_reg    <= sp_next;
            ovf_reg   <= ovf_next;
            ov_reg    <= ov_next;
            oe_reg    <= oe_next;
            push_reg  <= push_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        i_reg  <= i_next;
        j_reg  <= j_next;
        p_reg  <= p_next;
        k_reg  <= k_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        sp_next    = sp_reg;
        ovf_next   = ovf_reg;
        ov_next    = ov_reg;
        oe_next    = oe_reg;
        push_next  = push_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        p_next     = p_reg;
        k_next     = k_reg;
        in_stall   = 1'b1;
        cmd        = '0;
        cmd.op     = qsort_pkg::MEM_NONE;
        stk_we     = 1'b0;
        stk_wa     = sp_reg[5:0];
        stk_wd     = '0;
        case (state_reg)
            qsort_pkg::ST_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (count_reg < CW'(SIZE))
                    begin
                        cmd.op = qsort_pkg::MEM_WR_IN;
                        cmd.addr = 6'(count_reg);
                        count_next = count_reg + 1'b1;
                    end
                    else
                        ovf_next = 1'b1;
                    if (in_last)
                        state_next = qsort_pkg::ST_START;
                end
            end
            qsort_pkg::ST_START:
            begin
                sp_next = '0;
                if (count_reg >= CW'(2))
                begin
                    stk_we = 1'b1;
                    stk_wa = '0;
                    stk_wd = {6'd0, 6'(count_reg - 1'b1)};
                    sp_next = 7'd1;
                end
                state_next = qsort_pkg::ST_POP;
            end
            qsort_pkg::ST_POP:
            begin
                if (sp_reg == '0)
                begin
                    k_next = '0;
                    state_next = qsort_pkg::ST_EMIT_RD;
                end
                else
                begin
                    sp_next = sp_reg - 1'b1;
                    state_next = qsort_pkg::ST_POP_WT;
                end
            end
            qsort_pkg::ST_POP_WT:
            begin
                lo_next = {1'b0, stk_rd_reg[11:6]};
                hi_next = {1'b0, stk_rd_reg[5:0]};
                state_next = qsort_pkg::ST_PIV_RD;
            end
            qsort_pkg::ST_PIV_RD:
            begin
                cmd.op = qsort_pkg::MEM_RD;
                cmd.addr = lo_reg[5:0];
                i_next = lo_reg + 1'b1;
                j_next = hi_reg;
                state_next = qsort_pkg::ST_PIV_WT;
            end
            qsort_pkg::ST_PIV_WT:
            begin
                cmd.cap_piv = 1'b1;
                cmd.cap_a = 1'b1;  // keep pivot word for the final swap
                state_next = qsort_pkg::ST_LOOP;
            end
            qsort_pkg::ST_LOOP:
            begin
                if (i_reg == j_reg)
                    state_next = qsort_pkg::ST_P_RD;
                else
                    state_next = qsort_pkg::ST_J_RD;
            end
            qsort_pkg::ST_J_RD:
            begin
                cmd.op = qsort_pkg::MEM_RD;
                cmd.addr = j_reg[5:0];
                state_next = qsort_pkg::ST_J_CHK;
            end
            qsort_pkg::ST_J_CHK:
            begin
                if (!stat.lt_piv && i_reg < j_reg)
                begin
                    j_next = j_reg - 1'b1;
                    state_next = qsort_pkg::ST_J_RD;
                end
                else
                begin
                    cmd.cap_b = 1'b1;
                    state_next = qsort_pkg::ST_I_RD;
                end
            end
            qsort_pkg::ST_I_RD:
            begin
                cmd.op = qsort_pkg::MEM_RD;
                cmd.addr = i_reg[5:0];
                state_next = qsort_pkg::ST_I_CHK;
            end
            qsort_pkg::ST_I_CHK:
            begin
                if (stat.lt_piv && i_reg < j_reg)
                begin
                    i_next = i_reg + 1'b1;
                    state_next = qsort_pkg::ST_I_RD;
                end
                else if (i_reg < j_reg)
                begin
                    // word at i goes to j, word at j (hold b) goes to i
                    cmd.op = qsort_pkg::MEM_WR_B;
                    cmd.addr = i_reg[5:0];
                    state_next = qsort_pkg::ST_SW_WJ;
                end
                else
                    state_next = qsort_pkg::ST_LOOP;
            end
            qsort_pkg::ST_SW_WJ:
            begin
                cmd.cap_b = 1'b1;
                state_next = qsort_pkg::ST_I_WT;
            end
            qsort_pkg::ST_I_WT:
            begin
                cmd.op = qsort_pkg::MEM_WR_B;
                cmd.addr = j_reg[5:0];
                state_next = qsort_pkg::ST_LOOP;
            end
            qsort_pkg::ST_P_RD:
            begin
                cmd.op = qsort_pkg::MEM_RD;
                cmd.addr = j_reg[5:0];
                state_next = qsort_pkg::ST_P_CHK;
            end
            qsort_pkg::ST_P_CHK:
            begin
                p_next = stat.lt_piv ? j_reg : j_reg - 1'b1;
                state_next = qsort_pkg::ST_PL_RD;
            end
            qsort_pkg::ST_PL_RD:
            begin
                cmd.op = qsort_pkg::MEM_RD;
                cmd.addr = p_reg[5:0];
                state_next = qsort_pkg::ST_PL_WT;
            end
            qsort_pkg::ST_PL_WT:
            begin
                cmd.cap_b = 1'b1;
                cmd.op = qsort_pkg::MEM_WR_HOLD;
                cmd.addr = p_reg[5:0];
                state_next = qsort_pkg::ST_PL_WR;
            end
            qsort_pkg::ST_PL_WR:
            begin
                cmd.op = qsort_pkg::MEM_WR_B;
                cmd.addr = lo_reg[5:0];
                push_next = 2'd0;
                state_next = qsort_pkg::ST_PUSH;
            end
            qsort_pkg::ST_PUSH:
            begin
                push_next = push_reg + 1'b1;
                if (push_reg == 2'd0)
                begin
                    if (p_reg > lo_reg + 7'd1 && sp_reg < 7'd64)
                    begin
                        stk_we = 1'b1;
                        stk_wd = {lo_reg[5:0], 6'(p_reg - 1'b1)};
                        sp_next = sp_reg + 1'b1;
                    end
                end
                else
                begin
                    if (hi_reg > p_reg + 7'd1 && sp_reg < 7'd64)
                    begin
                        stk_we = 1'b1;
                        stk_wd = {6'(p_reg + 1'b1), hi_reg[5:0]};
                        sp_next = sp_reg + 1'b1;
                    end
                    state_next = qsort_pkg::ST_POP;
                end
            end
            qsort_pkg::ST_EMIT_RD:
            begin
                cmd.op = qsort_pkg::MEM_RD;
                cmd.addr = k_reg[5:0];
                state_next = qsort_pkg::ST_EMIT_WT;
            end
            qsort_pkg::ST_EMIT_WT:
            begin
                ov_next = 1'b1;
                oe_next = (k_reg + 1'b1) == 7'(count_reg);
                state_next = qsort_pkg::ST_EMIT_OUT;
            end
            qsort_pkg::ST_EMIT_OUT:
            begin
                if (!out_stall)
                begin
                    ov_next = 1'b0;
                    oe_next = 1'b0;
                    k_next = k_reg + 1'b1;
                    if (oe_reg)
                    begin
                        count_next = '0;
                        ovf_next = 1'b0;
                        sp_next = '0;
                        state_next = qsort_pkg::ST_LOAD;
                    end
                    else
                        state_next = qsort_pkg::ST_EMIT_RD;
                end
            end
            default:
                state_next = qsort_pkg::ST_LOAD;
        endcase
        // a set with no stored element emits nothing
        if (state_reg == qsort_pkg::ST_POP && sp_reg == '0 && count_reg == '0)
        begin
            ovf_next = 1'b0;
            state_next = qsort_pkg::ST_LOAD;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_out_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == qsort_pkg::ST_LOAD |-> !ov_reg)
        else $error("output valid while loading");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SIZE))
        else $error("element count beyond capacity");
    a_ij_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == qsort_pkg::ST_LOOP |-> i_reg <= j_reg)
        else $error("scan indexes crossed");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && out_stall |=> ov_reg && $stable(oe_reg))
        else $error("stalled result changed");
`endif
endmodule

@@ src/quicksort_engine.sv @@
// quicksort_engine: loads one word per cycle; sort runs after the last item
// partition walks the single-port element memory: one read per compare, two writes per swap
// average sort does n log n compares, worst case O(n^2)
// emission reads each word and holds it on the output while out_stall is high, then reads the next
// reset (rst_n low, async) empties the set and the range stack
// ----------------------------------------------------------------------------
// quicksort_engine
// collects a set of signed words, sorts ascending in place, streams them out
// ----------------------------------------------------------------------------
module quicksort_engine #(
    parameter int SIZE      = qsort_pkg::SIZE_DEF,
    parameter int DATA_BITS = qsort_pkg::DATA_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  qsort_pkg::in_word_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output qsort_pkg::out_word_t out_data
);
    qsort_pkg::dp_cmd_t  cmd;
    qsort_pkg::dp_stat_t stat;
    logic [qsort_pkg::VALUE_W-1:0] rd_value;

    qsort_ctrl #(.SIZE(SIZE)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_last(in_data.last_item), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_end(out_data.end_of_set), .out_drop(out_data.dropped),
        .cmd(cmd), .stat(stat)
    );

    qsort_datapath #(.SIZE(SIZE), .DATA_BITS(DATA_BITS)) u_dp (
        .clk(clk), .in_value(in_data.value), .cmd(cmd), .stat(stat),
        .rd_value(rd_value)
    );

    assign out_data.sorted_value = rd_value;
endmodule

@@ sim/quicksort_engine_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quicksort_engine_tb
// streams sets of signed words into the sorter and checks every sorted word,
// its end flag and its dropped flag against a local sorting predictor
// ----------------------------------------------------------------------------
module quicksort_engine_tb;

    localparam int CAP = 64;
    localparam int NUM_RANDOM = 40;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    qsort_pkg::in_word_t  in_data;
    logic                 out_valid;
    logic                 out_stall;
    qsort_pkg::out_word_t out_data;

    quicksort_engine i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    // predictor state
    logic signed [31:0]   held_vals[$];
    bit                   set_overflow;
    qsort_pkg::out_word_t sorted_queue[$];
    int                   errors;

    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_cycles;

    typedef struct {
        logic [31:0] value;
        logic        last_item;
        bit          typed;
        logic [31:0] exp_value;
    } dir_row_t;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // quicksort with first element as pivot
    task automatic sort_and_emit();
        logic signed [31:0] a[$];
        int lo_q[$];
        int hi_q[$];
        int lo, hi, i, j, p;
        logic signed [31:0] piv, t;
        qsort_pkg::out_word_t w;
        a = held_vals;
        if (a.size() >= 2)
        begin
            lo_q.push_back(0);
            hi_q.push_back(a.size() - 1);
        end
        while (lo_q.size() > 0)
        begin
            lo = lo_q.pop_back();
            hi = hi_q.pop_back();
            piv = a[lo];
            i = lo + 1;
            j = hi;
            while (i != j)
            begin
                while (a[j] >= piv && i < j) j--;
                while (a[i] < piv && i < j) i++;
                if (i < j)
                begin
                    t = a[i]; a[i] = a[j]; a[j] = t;
                end
            end
            p = (a[j] < piv) ? j : j - 1;
            t = a[lo]; a[lo] = a[p]; a[p] = t;
            if (p - 1 > lo)
            begin
                lo_q.push_back(lo);
                hi_q.push_back(p - 1);
            end
            if (hi > p + 1)
            begin
                lo_q.push_back(p + 1);
                hi_q.push_back(hi);
            end
        end
        foreach (a[k])
        begin
            w.sorted_value = a[k];
            w.end_of_set = (k == a.size() - 1);
            w.dropped = set_overflow;
            sorted_queue.push_back(w);
        end
        held_vals.delete();
        set_overflow = 0;
    endtask

    task automatic take_word(logic [31:0] v, logic last);
        if (held_vals.size() < CAP)
            held_vals.push_back(v);
        else
            set_overflow = 1;
        if (last)
            sort_and_emit();
    endtask

    // drive one word and wait for acceptance
    task automatic send_word(logic [31:0] v, logic last);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.value <= v;
        in_data.last_item <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        take_word(v, last);
    endtask

    // drop valid for one cycle
    task automatic idle_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (sorted_queue.size() > 0) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(7) - 3;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_random_set(int n);
        for (int k = 0; k < n; k++)
            send_word(rand_value(), k == n - 1);
    endtask

    // receiver side and checking
    initial
    begin
        qsort_pkg::out_word_t exp_w;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (sorted_queue.size() == 0)
                begin
                    $display("%0t: unexpected word expected none actual %h", $time,
                             out_data);
                    errors++;
                end
                else
                begin
                    exp_w = sorted_queue.pop_front();
                    if (out_data.sorted_value !== exp_w.sorted_value)
                    begin
                        $display("%0t: sorted_value expected %h actual %h", $time,
                                 exp_w.sorted_value, out_data.sorted_value);
                        errors++;
                    end
                    if (out_data.end_of_set !== exp_w.end_of_set)
                    begin
                        $display("%0t: end_of_set expected %b actual %b", $time,
                                 exp_w.end_of_set, out_data.end_of_set);
                        errors++;
                    end
                    if (out_data.dropped !== exp_w.dropped)
                    begin
                        $display("%0t: dropped expected %b actual %b", $time,
                                 exp_w.dropped, out_data.dropped);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        dir_row_t dir_rows[$];
        dir_row_t r;
        int sent;
        int n;
        errors = 0;
        set_overflow = 0;
        hold_cycles = 0;
        send_idle_pct = 9;
        recv_idle_pct = 64;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: single-element sets read off directly, others predicted
        dir_rows = '{
            '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
            '{32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff},
            '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
            '{32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff},
            '{32'h7fff_ffff, 1'b0, 1'b0, 32'h0},
            '{32'h8000_0000, 1'b1, 1'b0, 32'h0},
            '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0005, 1'b1, 1'b0, 32'h0},
            '{32'h0000_0003, 1'b0, 1'b0, 32'h0},
            '{32'hffff_fffe, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0009, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0001, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0003, 1'b1, 1'b0, 32'h0},
            '{32'h0000_0001, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0002, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0004, 1'b1, 1'b0, 32'h0},
            '{32'h0000_0004, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0002, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0001, 1'b1, 1'b0, 32'h0}
        };
        foreach (dir_rows[k])
        begin
            r = dir_rows[k];
            send_word(r.value, r.last_item);
            if (r.typed && sorted_queue[$].sorted_value !== r.exp_value)
            begin
                $display("%0t: predictor expected %h actual %h", $time,
                         r.exp_value, sorted_queue[$].sorted_value);
                errors++;
            end
        end
        idle_input();

        // full store and overflow, including a dropped final word
        for (int k = 0; k < CAP + 3; k++)
            send_word(rand_value(), k == CAP + 2);
        idle_input();

        // long receiver hold while the sender keeps offering, block must fill up
        wait_drained();
        hold_cycles = 2000;
        send_random_set(20);
        send_random_set(10);
        idle_input();
        // sender pauses until all results are out
        wait_drained();

        sent = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 64 : 0;
            recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 9 : 0;
            while (sent < NUM_RANDOM * (phase + 1) / 3)
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(16, 9)
                                             : $urandom_range(8, 1);
                send_random_set(n);
                sent += n;
            end
        end
        idle_input();

        wait_drained();
        repeat (200) @(posedge clk);
        if (errors == 0 && sorted_queue.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

@@ files.f @@
src/qsort_pkg.sv
src/qsort_datapath.sv
src/qsort_ctrl.sv
src/quicksort_engine.sv
sim/quicksort_engine_tb.sv
